FILE: hdl/ila_pkg.sv
`default_nettype none
package ila_pkg;

   localparam int ILA_ANGLE_BITS = 32;

   // datapath widths and pipeline depths
   localparam int CORDIC_STEPS = 30;
   localparam int DP_W         = 34;
   localparam int DIV_STEPS    = 33;
   localparam int SQRT_STEPS   = 31;
   localparam int SQ_W         = 61;

   localparam logic signed [DP_W-1:0] CORDIC_GAIN = 34'h26DD3B6A;
   localparam logic signed [DP_W-1:0] Q30_ONE     = 34'h40000000;
   localparam logic signed [DP_W-1:0] TURN_HALF   = 34'h80000000;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   localparam logic [1:0] CSR_POLE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_SINE_SLACK = 2'd1;

   typedef enum logic {
      MODE_ROTATE,
      MODE_VECTOR
   } cordic_mode_type;

   // side data that travels with each item
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       flag;
   } tag_type;

   // atan(2^-k) in 32-bit turn units
   function automatic logic signed [DP_W-1:0] atan_turn(input int k);
      logic signed [DP_W-1:0] v;
      case (k)
         0:  v = 34'h20000000;
         1:  v = 34'h12E4051E;
         2:  v = 34'h09FB385B;
         3:  v = 34'h051111D4;
         4:  v = 34'h028B0D43;
         5:  v = 34'h0145D7E1;
         6:  v = 34'h00A2F61E;
         7:  v = 34'h00517C55;
         8:  v = 34'h0028BE53;
         9:  v = 34'h00145F2F;
         10: v = 34'h000A2F98;
         11: v = 34'h000517CC;
         12: v = 34'h00028BE6;
         13: v = 34'h000145F3;
         14: v = 34'h0000A2FA;
         15: v = 34'h0000517D;
         16: v = 34'h000028BE;
         17: v = 34'h0000145F;
         18: v = 34'h00000A30;
         19: v = 34'h00000518;
         20: v = 34'h0000028C;
         21: v = 34'h00000146;
         22: v = 34'h000000A3;
         23: v = 34'h00000051;
         24: v = 34'h00000029;
         25: v = 34'h00000014;
         26: v = 34'h0000000A;
         27: v = 34'h00000005;
         28: v = 34'h00000003;
         29: v = 34'h00000001;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/ila_rot_cell.sv
`default_nettype none
module ila_rot_cell #(
   parameter int                       STEP = 0,
   parameter ila_pkg::cordic_mode_type MODE = ila_pkg::MODE_ROTATE
) (
   input  wire logic                             clock,
   input  wire logic signed [ila_pkg::DP_W-1:0]  x_i,
   input  wire logic signed [ila_pkg::DP_W-1:0]  y_i,
   input  wire logic signed [ila_pkg::DP_W-1:0]  z_i,
   output logic signed [ila_pkg::DP_W-1:0]       x_o,
   output logic signed [ila_pkg::DP_W-1:0]       y_o,
   output logic signed [ila_pkg::DP_W-1:0]       z_o
);
   import ila_pkg::*;

   localparam logic signed [DP_W-1:0] ANGLE = atan_turn(STEP);

   logic signed [DP_W-1:0] dx, dy;
   logic                   pos;
   logic signed [DP_W-1:0] x_in, y_in, z_in;
   logic signed [DP_W-1:0] x_ff, y_ff, z_ff;

   always_comb begin
      dx  = y_i >>> STEP;
      dy  = x_i >>> STEP;
      // rotate toward zero angle, or toward zero y when vectoring
      pos = (MODE == MODE_ROTATE) ? !z_i[DP_W-1] : y_i[DP_W-1];
      if (pos) begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ANGLE;
      end else begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule
`default_nettype wire

FILE: hdl/ila_div_cell.sv
`default_nettype none
module ila_div_cell (
   input  wire logic        clock,
   input  wire logic [31:0] den_i,
   input  wire logic [32:0] nb_i,
   input  wire logic [31:0] r_i,
   input  wire logic [32:0] q_i,
   output logic [31:0]      den_o,
   output logic [32:0]      nb_o,
   output logic [31:0]      r_o,
   output logic [32:0]      q_o
);
   logic [31:0] rs;
   logic        ge;
   logic [31:0] den_ff, r_ff, r_in;
   logic [32:0] nb_ff, q_ff, nb_in, q_in;

   // one restoring step: bring down the next numerator bit
   always_comb begin
      rs    = {r_i[30:0], nb_i[32]};
      ge    = rs >= den_i;
      r_in  = ge ? rs - den_i : rs;
      q_in  = {q_i[31:0], ge};
      nb_in = {nb_i[31:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      den_ff <= den_i;
      nb_ff  <= nb_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
   end

   assign den_o = den_ff;
   assign nb_o  = nb_ff;
   assign r_o   = r_ff;
   assign q_o   = q_ff;

endmodule
`default_nettype wire

FILE: hdl/ila_sqrt_cell.sv
`default_nettype none
module ila_sqrt_cell #(
   parameter int STEP = 0
) (
   input  wire logic [ila_pkg::SQ_W-1:0] n_i,
   input  wire logic [ila_pkg::SQ_W-1:0] r_i,
   input  wire logic                     clock,
   output logic [ila_pkg::SQ_W-1:0]      n_o,
   output logic [ila_pkg::SQ_W-1:0]      r_o
);
   import ila_pkg::*;

   localparam logic [SQ_W:0] BIT = {{SQ_W{1'b0}}, 1'b1} << (2 * (SQRT_STEPS - 1 - STEP));

   logic [SQ_W:0]   trial;
   logic            ge;
   logic [SQ_W-1:0] n_in, r_in, n_ff, r_ff;

   always_comb begin
      trial = {1'b0, r_i} + BIT;
      ge    = {1'b0, n_i} >= trial;
      n_in  = ge ? n_i - trial[SQ_W-1:0] : n_i;
      r_in  = ge ? (r_i >> 1) + BIT[SQ_W-1:0] : r_i >> 1;
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      r_ff <= r_in;
   end

   assign n_o = n_ff;
   assign r_o = r_ff;

endmodule
`default_nettype wire

FILE: hdl/inclination_to_launch_azimuth.sv
`default_nettype none
// Launch azimuth from orbit inclination and site latitude.
// Request: raise start with req_inclination and req_site_latitude; the pair
// transfers at the rising edge where start is high and busy is low. busy stays
// low, so a new pair may transfer in every cycle.
// Response: after the request transfer, rsp_strobe is high for one cycle
// with rsp_status, rsp_azimuth_north and rsp_azimuth_south. Each request
// gives exactly one response, in order. Throughput is one item per cycle; the
// path runs through the cell chains: 30 rotation cells for each of the two
// cosines, 33 divider cells, 31 square-root cells, 30 vectoring cells and five
// staging registers.
// The receiver cannot stall: the response transfers at the edge that ends
// the strobe cycle.
// Configuration: csr_write_enable with csr_index and csr_write_data writes
// pole_limit (index 0) or sine_slack (index 1) at that edge; other indexes
// are dropped. Write only while no item is in flight.
// Reset (synchronous, active high) empties the pipeline and sets both
// registers to 1.
module inclination_to_launch_azimuth #(
   parameter int ANGLE_BITS = ila_pkg::ILA_ANGLE_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [ANGLE_BITS-1:0]        req_inclination,
   input  wire logic signed [ANGLE_BITS-1:0] req_site_latitude,
   input  wire logic                         csr_write_enable,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [30:0]                  csr_write_data,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_status,
   output logic [ANGLE_BITS-1:0]             rsp_azimuth_north,
   output logic [ANGLE_BITS-1:0]             rsp_azimuth_south
);
   import ila_pkg::*;

   localparam int LATENCY = CORDIC_STEPS * 2 + DIV_STEPS + SQRT_STEPS + 5;

   localparam logic [ANGLE_BITS-1:0] HALF_TURN =
      {1'b1, {(ANGLE_BITS - 1){1'b0}}};
   localparam logic signed [ANGLE_BITS-1:0] QUARTER_TURN =
      {2'b01, {(ANGLE_BITS - 2){1'b0}}};

   // ---------------------------------------------------------------- config
   logic [30:0] pole_limit_ff, sine_slack_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_limit_ff <= 31'd1;
         sine_slack_ff <= 31'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_POLE_LIMIT: pole_limit_ff <= csr_write_data;
            CSR_SINE_SLACK: sine_slack_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // ----------------------------------------------------------------- entry
   logic signed [DP_W-1:0] lat32, inc32, t_inc;
   logic                   inc_neg, bad_arg;

   // bring both angles to 32-bit turn units
   generate
      if (ANGLE_BITS >= 32) begin : g_narrow
         localparam int DS = ANGLE_BITS - 32;
         assign lat32 = DP_W'(req_site_latitude >>> DS);
         assign inc32 = DP_W'(req_inclination >> DS);
      end else begin : g_widen
         localparam int US = 32 - ANGLE_BITS;
         assign lat32 = DP_W'(req_site_latitude) <<< US;
         assign inc32 = DP_W'(req_inclination) <<< US;
      end
   endgenerate

   always_comb begin
      bad_arg = (req_inclination > HALF_TURN) || (req_site_latitude > QUARTER_TURN) ||
                (req_site_latitude < -QUARTER_TURN);
      // fold inclinations past a quarter turn back: cos(i) = -cos(half - i)
      inc_neg = inc32 > Q30_ONE;
      t_inc   = inc_neg ? TURN_HALF - inc32 : inc32;
   end

   tag_type                e_tag_ff;
   logic signed [DP_W-1:0] e_lz_ff, e_iz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_tag_ff <= '0;
      end else begin
         e_tag_ff.valid  <= start && !busy;
         e_tag_ff.status <= bad_arg ? ST_INVALID : ST_OK;
         e_tag_ff.flag   <= inc_neg;
      end
   end

   always_ff @(posedge clock) begin
      e_lz_ff <= lat32;
      e_iz_ff <= t_inc;
   end

   // -------------------------------------------------- cosine cell chains
   logic signed [DP_W-1:0] c_lx [0:CORDIC_STEPS];
   logic signed [DP_W-1:0] c_ly [0:CORDIC_STEPS];
   logic signed [DP_W-1:0] c_lz [0:CORDIC_STEPS];
   logic signed [DP_W-1:0] c_ix [0:CORDIC_STEPS];
   logic signed [DP_W-1:0] c_iy [0:CORDIC_STEPS];
   logic signed [DP_W-1:0] c_iz [0:CORDIC_STEPS];
   tag_type                c_tag [0:CORDIC_STEPS];

   assign c_lx[0]  = CORDIC_GAIN;
   assign c_ly[0]  = '0;
   assign c_lz[0]  = e_lz_ff;
   assign c_ix[0]  = CORDIC_GAIN;
   assign c_iy[0]  = '0;
   assign c_iz[0]  = e_iz_ff;
   assign c_tag[0] = e_tag_ff;

   generate
      for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cos
         tag_type tag_ff;

         ila_rot_cell #(.STEP(k), .MODE(MODE_ROTATE)) u_lat (
            .clock (clock),
            .x_i   (c_lx[k]),   .y_i (c_ly[k]),   .z_i (c_lz[k]),
            .x_o   (c_lx[k+1]), .y_o (c_ly[k+1]), .z_o (c_lz[k+1])
         );

         ila_rot_cell #(.STEP(k), .MODE(MODE_ROTATE)) u_inc (
            .clock (clock),
            .x_i   (c_ix[k]),   .y_i (c_iy[k]),   .z_i (c_iz[k]),
            .x_o   (c_ix[k+1]), .y_o (c_iy[k+1]), .z_o (c_iz[k+1])
         );

         always_ff @(posedge clock) begin
            if (reset) begin
               tag_ff <= '0;
            end else begin
               tag_ff <= c_tag[k];
            end
         end

         assign c_tag[k+1] = tag_ff;
      end
   endgenerate

   // ------------------------------------- pole check and divider operands
   logic signed [DP_W-1:0] cos_l, cos_i, cos_abs;
   logic [32:0]            mag;
   logic                   pole, quo_ovf;
   tag_type                p1_tag_in, p1_tag_ff;
   logic [31:0]            p1_den_ff, p1_r_ff;
   logic [32:0]            p1_nb_ff;

   always_comb begin
      cos_l   = c_lx[CORDIC_STEPS];
      cos_i   = c_tag[CORDIC_STEPS].flag ? -c_ix[CORDIC_STEPS] : c_ix[CORDIC_STEPS];
      cos_abs = cos_i[DP_W-1] ? -cos_i : cos_i;
      mag     = cos_abs[32:0];
      pole    = (cos_l <= 0) || (cos_l < $signed({3'b000, pole_limit_ff}));
      // quotient of 2^33 or more is far past any slack: flag it here
      quo_ovf = {2'b00, mag} >= {cos_l[31:0], 3'b000};
      p1_tag_in = c_tag[CORDIC_STEPS];
      if (p1_tag_in.status == ST_OK && (pole || quo_ovf)) begin
         p1_tag_in.status = ST_RANGE;
      end
      p1_tag_in.flag = cos_i[DP_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_tag_ff <= '0;
      end else begin
         p1_tag_ff <= p1_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_den_ff <= cos_l[31:0];
      p1_nb_ff  <= {mag[2:0], 30'd0};
      p1_r_ff   <= {2'b00, mag[32:3]};
   end

   // ---------------------------------------------------- divider cell chain
   logic [31:0] d_den [0:DIV_STEPS];
   logic [32:0] d_nb  [0:DIV_STEPS];
   logic [31:0] d_r   [0:DIV_STEPS];
   logic [32:0] d_q   [0:DIV_STEPS];
   tag_type     d_tag [0:DIV_STEPS];

   assign d_den[0] = p1_den_ff;
   assign d_nb[0]  = p1_nb_ff;
   assign d_r[0]   = p1_r_ff;
   assign d_q[0]   = '0;
   assign d_tag[0] = p1_tag_ff;

   generate
      for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
         tag_type tag_ff;

         ila_div_cell u_cell (
            .clock (clock),
            .den_i (d_den[j]),   .nb_i (d_nb[j]),   .r_i (d_r[j]),   .q_i (d_q[j]),
            .den_o (d_den[j+1]), .nb_o (d_nb[j+1]), .r_o (d_r[j+1]), .q_o (d_q[j+1])
         );

         always_ff @(posedge clock) begin
            if (reset) begin
               tag_ff <= '0;
            end else begin
               tag_ff <= d_tag[j];
            end
         end

         assign d_tag[j+1] = tag_ff;
      end
   endgenerate

   // --------------------------------------------- slack check and clamp
   logic [32:0]        quo;
   logic [31:0]        limit;
   logic [30:0]        quo_clamp;
   logic signed [31:0] sine;
   tag_type            p2_tag_in, p2_tag_ff;
   logic signed [31:0] p2_s_ff;

   always_comb begin
      quo       = d_q[DIV_STEPS];
      limit     = 32'h40000000 + {1'b0, sine_slack_ff};
      quo_clamp = (quo > 33'h040000000) ? 31'h40000000 : quo[30:0];
      sine      = d_tag[DIV_STEPS].flag ? -$signed({1'b0, quo_clamp})
                                        : $signed({1'b0, quo_clamp});
      p2_tag_in = d_tag[DIV_STEPS];
      if (p2_tag_in.status == ST_OK && quo > {1'b0, limit}) begin
         p2_tag_in.status = ST_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_tag_ff <= '0;
      end else begin
         p2_tag_ff <= p2_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      p2_s_ff <= sine;
   end

   // ------------------------------------------------ 1 - s^2 for the root
   logic signed [63:0] sine_sq;
   logic [SQ_W-1:0]    p3_n_in, p3_n_ff;
   logic signed [31:0] p3_s_ff;
   tag_type            p3_tag_ff;

   always_comb begin
      sine_sq = p2_s_ff * p2_s_ff;
      p3_n_in = {1'b1, {(SQ_W - 1){1'b0}}} - sine_sq[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_tag_ff <= '0;
      end else begin
         p3_tag_ff <= p2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_n_ff <= p3_n_in;
      p3_s_ff <= p2_s_ff;
   end

   // ------------------------------------------------ square-root cell chain
   logic [SQ_W-1:0]    q_n   [0:SQRT_STEPS];
   logic [SQ_W-1:0]    q_r   [0:SQRT_STEPS];
   logic signed [31:0] q_s   [0:SQRT_STEPS];
   tag_type            q_tag [0:SQRT_STEPS];

   assign q_n[0]   = p3_n_ff;
   assign q_r[0]   = '0;
   assign q_s[0]   = p3_s_ff;
   assign q_tag[0] = p3_tag_ff;

   generate
      for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
         tag_type            tag_ff;
         logic signed [31:0] s_ff;

         ila_sqrt_cell #(.STEP(i)) u_cell (
            .clock (clock),
            .n_i   (q_n[i]),   .r_i (q_r[i]),
            .n_o   (q_n[i+1]), .r_o (q_r[i+1])
         );

         always_ff @(posedge clock) begin
            if (reset) begin
               tag_ff <= '0;
            end else begin
               tag_ff <= q_tag[i];
            end
         end

         // hold the sine alongside for the vectoring chain
         always_ff @(posedge clock) begin
            s_ff <= q_s[i];
         end

         assign q_tag[i+1] = tag_ff;
         assign q_s[i+1]   = s_ff;
      end
   endgenerate

   // ----------------------------------------------- arcsine vectoring chain
   logic signed [DP_W-1:0] v_x   [0:CORDIC_STEPS];
   logic signed [DP_W-1:0] v_y   [0:CORDIC_STEPS];
   logic signed [DP_W-1:0] v_z   [0:CORDIC_STEPS];
   tag_type                v_tag [0:CORDIC_STEPS];

   assign v_x[0]   = {3'b000, q_r[SQRT_STEPS][30:0]};
   assign v_y[0]   = DP_W'(q_s[SQRT_STEPS]);
   assign v_z[0]   = '0;
   assign v_tag[0] = q_tag[SQRT_STEPS];

   generate
      for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
         tag_type tag_ff;

         ila_rot_cell #(.STEP(k), .MODE(MODE_VECTOR)) u_cell (
            .clock (clock),
            .x_i   (v_x[k]),   .y_i (v_y[k]),   .z_i (v_z[k]),
            .x_o   (v_x[k+1]), .y_o (v_y[k+1]), .z_o (v_z[k+1])
         );

         always_ff @(posedge clock) begin
            if (reset) begin
               tag_ff <= '0;
            end else begin
               tag_ff <= v_tag[k];
            end
         end

         assign v_tag[k+1] = tag_ff;
      end
   endgenerate

   // ---------------------------------------------------------------- output
   logic [31:0]           turn_n, turn_s;
   logic [ANGLE_BITS-1:0] az_n, az_s;
   tag_type               out_tag;
   logic                  out_ok;

   assign out_tag = v_tag[CORDIC_STEPS];
   assign out_ok  = out_tag.status == ST_OK;
   assign turn_n  = v_z[CORDIC_STEPS][31:0];
   assign turn_s  = 32'h80000000 - turn_n;

   // scale back from 32-bit turn units
   generate
      if (ANGLE_BITS >= 32) begin : g_out_wide
         localparam int DS = ANGLE_BITS - 32;
         assign az_n = ANGLE_BITS'(turn_n) << DS;
         assign az_s = ANGLE_BITS'(turn_s) << DS;
      end else begin : g_out_narrow
         assign az_n = turn_n[31 -: ANGLE_BITS];
         assign az_s = turn_s[31 -: ANGLE_BITS];
      end
   endgenerate

   logic                  rsp_strobe_ff;
   logic [1:0]            rsp_status_ff;
   logic [ANGLE_BITS-1:0] rsp_north_ff, rsp_south_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= out_tag.valid;
      end
   end

   // drop the angles on any failed item
   always_ff @(posedge clock) begin
      rsp_status_ff <= out_tag.status;
      rsp_north_ff  <= out_ok ? az_n : '0;
      rsp_south_ff  <= out_ok ? az_s : '0;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_azimuth_north = rsp_north_ff;
   assign rsp_azimuth_south = rsp_south_ff;

   // ------------------------------------------------------------ assertions
   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("request transfer without response at fixed latency");

   a_latency_back : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("response without matching request transfer");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |->
         (rsp_azimuth_north == '0 && rsp_azimuth_south == '0))
      else $error("failed item carries nonzero azimuth");

endmodule
`default_nettype wire
